/* rtl/assert_macros.svh */
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/pps_pkg.sv */
package pps_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [6:0] COLS_RESET   = 7'd64;
    localparam logic [6:0] ROWS_RESET   = 7'd64;
    localparam logic [7:0] SWEEPS_RESET = 8'd200;

    localparam logic [1:0] REG_COLS   = 2'd0;
    localparam logic [1:0] REG_ROWS   = 2'd1;
    localparam logic [1:0] REG_SWEEPS = 2'd2;

    typedef enum logic [2:0] {
        CMD_WR_U  = 3'd0,
        CMD_WR_V  = 3'd1,
        CMD_WR_S  = 3'd2,
        CMD_SOLVE = 3'd3,
        CMD_RD_U  = 3'd4,
        CMD_RD_V  = 3'd5,
        CMD_RD_P  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_SOLVED  = 2'd2
    } t_status;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_READ = 9'b000000100,
        S_ZERO = 9'b000001000,
        S_CELL = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_DWR  = 9'b001000000,
        S_UF   = 9'b010000000,
        S_VF   = 9'b100000000
    } t_state;

endpackage

/* rtl/pps_ram.sv */
module pps_ram #(
    parameter int Width = 32,
    parameter int Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pressure_projection_solver_top.sv */
// Pressure projection on a staggered grid, signed Q16.16 values.
// Items enter on the s_axis channel (tuser = command) and each one gives
// exactly one result item on m_axis (tdata = value read, tuser = status).
// Registers (columns, rows, sweep count) sit on the APB port, pready tied high.
// Face and solid writes are answered from the idle state; reads pass through
// S_READ, bounded by the registered read of the face and pressure memories.
// A solve first zeroes the pressures, then runs the cell steps for every
// sweep and cell, with a bit-serial divide by the neighbor count for each
// fluid cell that has a fluid neighbor, then updates every interior face;
// one saturating adder does the value arithmetic outside the divide.
// One item is in work at a time; s_axis_tready is low until it is done and
// its result has a free output register.
// After reset the block clears pressures and solid flags at all
// MAX_COLUMNS*MAX_ROWS cells and takes no item meanwhile; register
// writes are taken at any time.
// A stalled receiver holds the result in the output register and
// blocks the next item.
module pressure_projection_solver_top #(
    parameter int MaxColumns = pps_pkg::DEF_MAX_COLUMNS,
    parameter int MaxRows    = pps_pkg::DEF_MAX_ROWS,
    parameter int ValueWidth = pps_pkg::DEF_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // col_index[6:0], row_index[13:7], write_value[45:14], solid_flag[46], zero
    input  logic [47:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_value[31:0]
    output logic [31:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W  = ValueWidth;
    localparam int CW = $clog2(MaxColumns + 1);
    localparam int RW = $clog2(MaxRows + 1);
    localparam int CD = MaxColumns * MaxRows;
    localparam int UD = (MaxColumns + 1) * MaxRows;
    localparam int VD = MaxColumns * (MaxRows + 1);
    localparam int CA = $clog2(CD);
    localparam int UA = $clog2(UD);
    localparam int VA = $clog2(VD);
    localparam int DW = $clog2(W);
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
    localparam logic signed [63:0] RMAX = 64'sd2147483647;
    localparam logic signed [63:0] RMIN = -64'sd2147483648;

    pps_pkg::t_state r_state;
    logic [3:0]      r_step;
    logic [6:0]      r_cfg_cols;
    logic [6:0]      r_cfg_rows;
    logic [7:0]      r_cfg_sweeps;
    logic [CA-1:0]   r_clr;
    logic [CW-1:0]   r_c;
    logic [RW-1:0]   r_r;
    logic [7:0]      r_sweep;
    logic signed [W-1:0] r_acc;
    logic signed [W-1:0] r_div;
    logic [W-1:0]    r_q;
    logic [1:0]      r_rem;
    logic [DW-1:0]   r_dbit;
    logic            r_neg;
    logic [2:0]      r_cnt;
    logic            r_self;
    logic            r_nb;
    pps_pkg::t_cmd   r_cmd;
    logic            r_ovalid;
    logic [31:0]     r_odata;
    logic [1:0]      r_ostat;

    logic [CW-1:0] nc;
    logic [RW-1:0] nr;
    logic          last_c;
    logic          last_r;
    int            at_i;
    logic [CA-1:0] at;
    logic [UA-1:0] uidx;

    logic          in_acc;
    pps_pkg::t_cmd in_cmd;
    int            in_c;
    int            in_r;
    logic          u_ok;
    logic          v_ok;
    logic          c_ok;
    logic signed [63:0] wv64;
    logic signed [W-1:0] wv;

    logic          u_we;
    logic [UA-1:0] u_waddr;
    logic [UA-1:0] u_raddr;
    logic [W-1:0]  u_wdata;
    logic [W-1:0]  q_u;
    logic          v_we;
    logic [VA-1:0] v_waddr;
    logic [VA-1:0] v_raddr;
    logic [W-1:0]  v_wdata;
    logic [W-1:0]  q_v;
    logic          p_we;
    logic [CA-1:0] p_waddr;
    logic [CA-1:0] p_raddr;
    logic [W-1:0]  p_wdata;
    logic [W-1:0]  q_p;
    logic          s_we;
    logic [CA-1:0] s_waddr;
    logic          s_wdata;
    logic          q_s;

    logic signed [W-1:0] alu_a;
    logic signed [W-1:0] alu_b;
    logic                alu_sub;
    logic signed [W-1:0] alu_y;
    logic [2:0]          rem_sh;
    logic                rem_ge;
    logic                cfg_wr;
    logic                rd_in;

    function automatic logic signed [W-1:0] f_sat(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b,
                                                  input logic sub);
        logic signed [W:0] s;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        if (s[W] != s[W-1]) begin
            return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return s[W-1:0];
    endfunction

    function automatic logic [31:0] f_rd32(input logic [W-1:0] x);
        logic signed [63:0] e;
        e = 64'(signed'(x));
        if (e > RMAX) e = RMAX;
        if (e < RMIN) e = RMIN;
        return e[31:0];
    endfunction

    // effective grid size
    always_comb begin
        if (r_cfg_cols == 7'd0) nc = CW'(1);
        else if (int'(r_cfg_cols) > MaxColumns) nc = CW'(MaxColumns);
        else nc = CW'(r_cfg_cols);
        if (r_cfg_rows == 7'd0) nr = RW'(1);
        else if (int'(r_cfg_rows) > MaxRows) nr = RW'(MaxRows);
        else nr = RW'(r_cfg_rows);
    end

    assign last_c = (r_c == nc - CW'(1));
    assign last_r = (r_r == nr - RW'(1));
    assign at_i   = int'(r_r) * MaxColumns + int'(r_c);
    assign at     = CA'(at_i);
    assign uidx   = UA'(int'(r_r) * (MaxColumns + 1) + int'(r_c));

    // input decode
    assign s_axis_tready = (r_state == pps_pkg::S_IDLE) && (!r_ovalid || m_axis_tready);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_cmd = pps_pkg::t_cmd'(s_axis_tuser);
    assign in_c   = int'(s_axis_tdata[6:0]);
    assign in_r   = int'(s_axis_tdata[13:7]);
    assign u_ok   = (in_c <= int'(nc)) && (in_r < int'(nr));
    assign v_ok   = (in_c < int'(nc)) && (in_r <= int'(nr));
    assign c_ok   = (in_c < int'(nc)) && (in_r < int'(nr));

    always_comb begin
        wv64 = 64'(signed'(s_axis_tdata[45:14]));
        if (wv64 > VMAX) wv64 = VMAX;
        if (wv64 < VMIN) wv64 = VMIN;
        wv = W'(wv64);
    end

    assign rem_sh = {r_rem, r_q[W-1]};
    assign rem_ge = (rem_sh >= r_cnt);
    assign alu_y  = f_sat(alu_a, alu_b, alu_sub);

    // memory ports and shared adder operands
    always_comb begin
        u_we    = 1'b0;
        u_waddr = uidx;
        u_wdata = alu_y;
        u_raddr = uidx;
        v_we    = 1'b0;
        v_waddr = VA'(at_i);
        v_wdata = alu_y;
        v_raddr = VA'(at_i);
        p_we    = 1'b0;
        p_waddr = at;
        p_wdata = '0;
        p_raddr = at;
        s_we    = 1'b0;
        s_waddr = at;
        s_wdata = 1'b0;
        alu_a   = r_acc;
        alu_b   = signed'(q_p);
        alu_sub = 1'b0;
        unique case (r_state)
            pps_pkg::S_CLR: begin
                p_we    = 1'b1;
                p_waddr = r_clr;
                s_we    = 1'b1;
                s_waddr = r_clr;
            end
            pps_pkg::S_IDLE: begin
                u_raddr = UA'(in_c + (MaxColumns + 1) * in_r);
                v_raddr = VA'(in_c + MaxColumns * in_r);
                p_raddr = CA'(in_c + MaxColumns * in_r);
                u_waddr = u_raddr;
                v_waddr = v_raddr;
                s_waddr = p_raddr;
                u_wdata = wv;
                v_wdata = wv;
                s_wdata = s_axis_tdata[46];
                u_we    = in_acc && (in_cmd == pps_pkg::CMD_WR_U) && u_ok;
                v_we    = in_acc && (in_cmd == pps_pkg::CMD_WR_V) && v_ok;
                s_we    = in_acc && (in_cmd == pps_pkg::CMD_WR_S) && c_ok;
            end
            pps_pkg::S_ZERO: begin
                p_we = 1'b1;
            end
            pps_pkg::S_CELL: begin
                case (r_step)
                    4'd0: u_raddr = uidx + UA'(1);
                    4'd2: begin
                        alu_b   = signed'(q_u);
                        alu_sub = 1'b1;
                        v_raddr = VA'(at_i + MaxColumns);
                    end
                    4'd3: alu_b = signed'(q_v);
                    4'd4: begin
                        alu_b   = signed'(q_v);
                        alu_sub = 1'b1;
                    end
                    4'd5: if (r_c != '0) p_raddr = CA'(at_i - 1);
                    4'd6: if (!last_c) p_raddr = CA'(at_i + 1);
                    4'd7: if (r_r != '0) p_raddr = CA'(at_i - MaxColumns);
                    4'd8: if (!last_r) p_raddr = CA'(at_i + MaxColumns);
                    4'd10: begin
                        alu_b   = r_div;
                        alu_sub = 1'b1;
                    end
                    4'd11: p_we = r_self;
                    default: ;
                endcase
            end
            pps_pkg::S_DWR: begin
                p_wdata = r_neg ? (~r_q + W'(1)) : r_q;
                p_we    = !r_self && (r_cnt != 3'd0);
            end
            pps_pkg::S_UF, pps_pkg::S_VF: begin
                if (r_step == 4'd0) begin
                    p_raddr = (r_state == pps_pkg::S_UF) ? CA'(at_i - 1)
                                                         : CA'(at_i - MaxColumns);
                end
                if (r_step == 4'd2) begin
                    alu_a   = signed'(q_p);
                    alu_b   = r_acc;
                    alu_sub = 1'b1;
                end
                if (r_step == 4'd3) begin
                    alu_a   = r_div;
                    alu_b   = r_acc;
                    alu_sub = 1'b1;
                    u_we    = (r_state == pps_pkg::S_UF) && !r_self && !r_nb;
                    v_we    = (r_state == pps_pkg::S_VF) && !r_self && !r_nb;
                end
            end
            default: ;
        endcase
    end

    pps_ram #(.Width(W), .Depth(UD)) u_ram_u (
        .i_clk(i_clk), .i_we(u_we), .i_waddr(u_waddr), .i_wdata(u_wdata),
        .i_raddr(u_raddr), .o_rdata(q_u)
    );

    pps_ram #(.Width(W), .Depth(VD)) u_ram_v (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(q_v)
    );

    pps_ram #(.Width(W), .Depth(CD)) u_ram_p (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(q_p)
    );

    pps_ram #(.Width(1), .Depth(CD)) u_ram_s (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(p_raddr), .o_rdata(q_s)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            pps_pkg::REG_COLS:   prdata = {25'd0, r_cfg_cols};
            pps_pkg::REG_ROWS:   prdata = {25'd0, r_cfg_rows};
            pps_pkg::REG_SWEEPS: prdata = {24'd0, r_cfg_sweeps};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols   <= pps_pkg::COLS_RESET;
            r_cfg_rows   <= pps_pkg::ROWS_RESET;
            r_cfg_sweeps <= pps_pkg::SWEEPS_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                pps_pkg::REG_COLS:   r_cfg_cols   <= pwdata[6:0];
                pps_pkg::REG_ROWS:   r_cfg_rows   <= pwdata[6:0];
                pps_pkg::REG_SWEEPS: r_cfg_sweeps <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign rd_in = ((in_cmd == pps_pkg::CMD_RD_U) && u_ok)
                || ((in_cmd == pps_pkg::CMD_RD_V) && v_ok)
                || ((in_cmd == pps_pkg::CMD_RD_P) && c_ok);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pps_pkg::S_CLR;
            r_step   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_c      <= '0;
            r_r      <= '0;
            r_sweep  <= '0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                pps_pkg::S_CLR: begin
                    r_clr <= r_clr + CA'(1);
                    if (r_clr == CA'(CD - 1)) r_state <= pps_pkg::S_IDLE;
                end
                pps_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= in_cmd;
                        r_odata <= '0;
                        if (in_cmd == pps_pkg::CMD_SOLVE) begin
                            r_c     <= '0;
                            r_r     <= '0;
                            r_sweep <= '0;
                            r_state <= pps_pkg::S_ZERO;
                        end else if (rd_in) begin
                            r_state <= pps_pkg::S_READ;
                        end else begin
                            r_ovalid <= 1'b1;
                            r_ostat  <= pps_pkg::ST_IGNORED;
                            if (((in_cmd == pps_pkg::CMD_WR_U) && u_ok)
                                || ((in_cmd == pps_pkg::CMD_WR_V) && v_ok)
                                || ((in_cmd == pps_pkg::CMD_WR_S) && c_ok)) begin
                                r_ostat <= pps_pkg::ST_OK;
                            end
                        end
                    end
                end
                pps_pkg::S_READ: begin
                    r_ovalid <= 1'b1;
                    r_ostat  <= pps_pkg::ST_OK;
                    case (r_cmd)
                        pps_pkg::CMD_RD_U: r_odata <= f_rd32(q_u);
                        pps_pkg::CMD_RD_V: r_odata <= f_rd32(q_v);
                        default:           r_odata <= f_rd32(q_p);
                    endcase
                    r_state <= pps_pkg::S_IDLE;
                end
                pps_pkg::S_ZERO: begin
                    r_step <= '0;
                    if (!last_c) begin
                        r_c <= r_c + CW'(1);
                    end else begin
                        r_c <= '0;
                        if (!last_r) begin
                            r_r <= r_r + RW'(1);
                        end else begin
                            r_r <= '0;
                            if (r_cfg_sweeps == 8'd0) begin
                                r_c     <= CW'(1);
                                r_state <= (nc == CW'(1)) ? pps_pkg::S_VF : pps_pkg::S_UF;
                                if (nc == CW'(1)) begin
                                    r_c <= '0;
                                    r_r <= RW'(1);
                                end
                            end else begin
                                r_state <= pps_pkg::S_CELL;
                            end
                        end
                    end
                end
                pps_pkg::S_CELL: begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd1: r_acc <= signed'(q_u);
                        4'd2, 4'd3: r_acc <= alu_y;
                        4'd4: begin
                            r_div <= alu_y;
                            r_acc <= '0;
                            r_cnt <= '0;
                        end
                        4'd5: r_self <= q_s;
                        4'd6: if (r_c != '0 && !q_s) begin
                            r_acc <= alu_y;
                            r_cnt <= r_cnt + 3'd1;
                        end
                        4'd7: if (!last_c && !q_s) begin
                            r_acc <= alu_y;
                            r_cnt <= r_cnt + 3'd1;
                        end
                        4'd8: if (r_r != '0 && !q_s) begin
                            r_acc <= alu_y;
                            r_cnt <= r_cnt + 3'd1;
                        end
                        4'd9: if (!last_r && !q_s) begin
                            r_acc <= alu_y;
                            r_cnt <= r_cnt + 3'd1;
                        end
                        4'd10: r_acc <= alu_y;
                        4'd11: begin
                            if (!r_self && r_cnt != 3'd0) begin
                                r_neg   <= r_acc[W-1];
                                r_q     <= r_acc[W-1] ? (~r_acc + W'(1)) : r_acc;
                                r_rem   <= '0;
                                r_dbit  <= DW'(W - 1);
                                r_state <= pps_pkg::S_DIV;
                            end else begin
                                r_state <= pps_pkg::S_DWR;
                            end
                        end
                        default: ;
                    endcase
                end
                pps_pkg::S_DIV: begin
                    r_rem  <= rem_ge ? 2'(rem_sh - r_cnt) : rem_sh[1:0];
                    r_q    <= {r_q[W-2:0], rem_ge};
                    r_dbit <= r_dbit - DW'(1);
                    if (r_dbit == '0) r_state <= pps_pkg::S_DWR;
                end
                pps_pkg::S_DWR: begin
                    // also the exit of solid or isolated cells, where the write is masked
                    r_step  <= '0;
                    r_state <= pps_pkg::S_CELL;
                    if (!last_c) begin
                        r_c <= r_c + CW'(1);
                    end else begin
                        r_c <= '0;
                        if (!last_r) begin
                            r_r <= r_r + RW'(1);
                        end else begin
                            r_r <= '0;
                            if ({1'b0, r_sweep} + 9'd1 != {1'b0, r_cfg_sweeps}) begin
                                r_sweep <= r_sweep + 8'd1;
                            end else if (nc == CW'(1)) begin
                                r_r     <= RW'(1);
                                r_state <= pps_pkg::S_VF;
                            end else begin
                                r_c     <= CW'(1);
                                r_state <= pps_pkg::S_UF;
                            end
                        end
                    end
                end
                pps_pkg::S_UF, pps_pkg::S_VF: begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd1: begin
                            r_self <= q_s;
                            r_acc  <= signed'(q_p);
                            r_div  <= (r_state == pps_pkg::S_UF) ? signed'(q_u) : signed'(q_v);
                        end
                        4'd2: begin
                            r_acc <= alu_y;
                            r_nb  <= q_s;
                        end
                        4'd3: begin
                            r_step <= '0;
                            if (!last_c) begin
                                r_c <= r_c + CW'(1);
                            end else if (!last_r) begin
                                r_r <= r_r + RW'(1);
                                r_c <= (r_state == pps_pkg::S_UF) ? CW'(1) : '0;
                            end else if (r_state == pps_pkg::S_UF && nr != RW'(1)) begin
                                r_c     <= '0;
                                r_r     <= RW'(1);
                                r_state <= pps_pkg::S_VF;
                            end else begin
                                r_ovalid <= 1'b1;
                                r_ostat  <= pps_pkg::ST_SOLVED;
                                r_odata  <= '0;
                                r_state  <= pps_pkg::S_IDLE;
                            end
                        end
                        default: ;
                    endcase
                    if (r_step == 4'd0 && r_state == pps_pkg::S_VF && nr == RW'(1)) begin
                        r_ovalid <= 1'b1;
                        r_ostat  <= pps_pkg::ST_SOLVED;
                        r_odata  <= '0;
                        r_state  <= pps_pkg::S_IDLE;
                    end
                end
                default: r_state <= pps_pkg::S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostat;

`include "assert_macros.svh"

    `ASSERT_CLKD(a_no_take_on_stall, (r_ovalid && !m_axis_tready) |-> !s_axis_tready, "item taken while result stalled")
    `ASSERT_CLKD(a_div_rem, (r_state == pps_pkg::S_DIV) |-> (r_rem < r_cnt && r_cnt != 3'd0), "divider remainder out of range")
    `ASSERT_CLKD(a_u_we_state, u_we |-> (r_state == pps_pkg::S_IDLE || r_state == pps_pkg::S_UF), "face write outside load or update")
    `ASSERT_CLKD(a_solve_result, (r_state == pps_pkg::S_IDLE && $past(r_state) == pps_pkg::S_VF) |-> (r_ovalid && r_ostat == pps_pkg::ST_SOLVED), "solve ended without result")

endmodule
